[hw/rtl/lav_pkg.sv]
package lav_pkg;

  localparam int QW   = 32;
  localparam int FRAC = 16;
  localparam int AXW  = FRAC + 2;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [QW-1:0] pos_x;
    logic signed [QW-1:0] pos_y;
    logic signed [QW-1:0] pos_z;
    logic signed [QW-1:0] target_x;
    logic signed [QW-1:0] target_y;
    logic signed [QW-1:0] target_z;
    logic signed [QW-1:0] up_x;
    logic signed [QW-1:0] up_y;
    logic signed [QW-1:0] up_z;
  } lav_in_t;

  typedef struct packed {
    logic signed [QW-1:0] right_axis_x;
    logic signed [QW-1:0] right_axis_y;
    logic signed [QW-1:0] right_axis_z;
    logic signed [QW-1:0] right_shift;
    logic signed [QW-1:0] true_up_x;
    logic signed [QW-1:0] true_up_y;
    logic signed [QW-1:0] true_up_z;
    logic signed [QW-1:0] up_shift;
    logic signed [QW-1:0] back_axis_x;
    logic signed [QW-1:0] back_axis_y;
    logic signed [QW-1:0] back_axis_z;
    logic signed [QW-1:0] back_shift;
  } lav_out_t;

  // q32.32 to q16.16, half away from zero
  function automatic logic signed [63:0] round16(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] q;
    m = v[63] ? $unsigned(-v) : $unsigned(v);
    q = (m + 64'd32768) >> FRAC;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

endpackage

[hw/rtl/lav_unit.sv]
module lav_unit import lav_pkg::*; #(
  parameter int IW = 34,
  parameter int SW = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic signed [IW-1:0]  in_vec [3],
  input  logic [SW-1:0]         in_side,
  output logic                  out_vld,
  output logic signed [AXW-1:0] out_vec [3],
  output logic [SW-1:0]         out_side
);

  localparam int PW  = $clog2(IW);
  localparam int NRM = 30;
  localparam int SQW = 2 * NRM;
  localparam int SSW = SQW + 2;
  localparam int ISQ = SSW / 2;
  localparam int RW  = SSW + 1;
  localparam int LW  = ISQ;
  localparam int QB  = FRAC + 1;
  localparam int NW  = NRM + FRAC + 1;
  localparam int DRW = LW + 1;
  localparam int LAT = 4 + 1 + ISQ + 1 + QB + 1;

  logic [LAT-1:0] vld_r;

  logic [IW-1:0]  mag_a_r [3];
  logic [2:0]     neg_a_r;
  logic [SW-1:0]  side_a_r;

  logic [IW-1:0]  mor;
  logic [PW-1:0]  pos_nxt;
  logic [IW-1:0]  mag_b_r [3];
  logic [2:0]     neg_b_r;
  logic           zero_b_r;
  logic [PW-1:0]  pos_b_r;
  logic [SW-1:0]  side_b_r;

  logic [NRM-1:0] nm_c_r [3];
  logic [2:0]     neg_c_r;
  logic           zero_c_r;
  logic [SW-1:0]  side_c_r;

  logic [SQW-1:0] sq_d_r [3];
  logic [NRM-1:0] nm_d_r [3];
  logic [2:0]     neg_d_r;
  logic           zero_d_r;
  logic [SW-1:0]  side_d_r;

  logic [RW-1:0]  rem_r   [ISQ+1];
  logic [RW-1:0]  res_r   [ISQ+1];
  logic [RW-1:0]  trial   [ISQ];
  logic [NRM-1:0] nm_s_r  [ISQ+1][3];
  logic [2:0]     neg_s_r [ISQ+1];
  logic [ISQ:0]   zero_s_r;
  logic [SW-1:0]  side_s_r [ISQ+1];

  logic [NW-1:0]  num_nxt [3];
  logic [NW-1:0]  num_r   [QB+1][3];
  logic [DRW-1:0] drem_r  [QB+1][3];
  logic [DRW-1:0] dtry    [QB][3];
  logic [QB-1:0]  quo_r   [QB+1][3];
  logic [LW-1:0]  len_r   [QB+1];
  logic [2:0]     neg_v_r [QB+1];
  logic [QB:0]    zero_v_r;
  logic [SW-1:0]  side_v_r [QB+1];

  logic signed [AXW-1:0] out_vec_r [3];
  logic [SW-1:0]         side_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
  end

  // magnitudes
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg_a_r[i] <= in_vec[i][IW-1];
      mag_a_r[i] <= in_vec[i][IW-1] ? IW'(-in_vec[i]) : IW'(in_vec[i]);
    end
    side_a_r <= in_side;
  end

  // leading one of the largest magnitude
  always_comb begin
    mor     = mag_a_r[0] | mag_a_r[1] | mag_a_r[2];
    pos_nxt = '0;
    for (int k = 0; k < IW; k++) begin
      if (mor[k]) pos_nxt = PW'(k);
    end
  end

  always_ff @(posedge clk) begin
    mag_b_r  <= mag_a_r;
    neg_b_r  <= neg_a_r;
    zero_b_r <= (mor == '0);
    pos_b_r  <= pos_nxt;
    side_b_r <= side_a_r;
  end

  // bring the top bit to bit 29
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (pos_b_r >= PW'(NRM - 1)) begin
        nm_c_r[i] <= NRM'(mag_b_r[i] >> (pos_b_r - PW'(NRM - 1)));
      end else begin
        nm_c_r[i] <= NRM'(mag_b_r[i] << (PW'(NRM - 1) - pos_b_r));
      end
    end
    neg_c_r  <= neg_b_r;
    zero_c_r <= zero_b_r;
    side_c_r <= side_b_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_d_r[i] <= nm_c_r[i] * nm_c_r[i];
    end
    nm_d_r   <= nm_c_r;
    neg_d_r  <= neg_c_r;
    zero_d_r <= zero_c_r;
    side_d_r <= side_c_r;
  end

  // sum of squares, then one root bit per stage
  always_comb begin
    for (int j = 0; j < ISQ; j++) begin
      trial[j] = res_r[j] + (RW'(1) << (2 * (ISQ - 1 - j)));
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]    <= RW'(sq_d_r[0]) + RW'(sq_d_r[1]) + RW'(sq_d_r[2]);
    res_r[0]    <= '0;
    nm_s_r[0]   <= nm_d_r;
    neg_s_r[0]  <= neg_d_r;
    zero_s_r[0] <= zero_d_r;
    side_s_r[0] <= side_d_r;
    for (int j = 0; j < ISQ; j++) begin
      if (rem_r[j] >= trial[j]) begin
        rem_r[j+1] <= rem_r[j] - trial[j];
        res_r[j+1] <= (res_r[j] >> 1) + (RW'(1) << (2 * (ISQ - 1 - j)));
      end else begin
        rem_r[j+1] <= rem_r[j];
        res_r[j+1] <= res_r[j] >> 1;
      end
      nm_s_r[j+1]   <= nm_s_r[j];
      neg_s_r[j+1]  <= neg_s_r[j];
      zero_s_r[j+1] <= zero_s_r[j];
      side_s_r[j+1] <= side_s_r[j];
    end
  end

  // m * 2^16 + len / 2, then one quotient bit per stage
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_nxt[i] = (NW'(nm_s_r[ISQ][i]) << FRAC) + NW'(res_r[ISQ][LW-1:1]);
    end
    for (int j = 0; j < QB; j++) begin
      for (int i = 0; i < 3; i++) begin
        dtry[j][i] = {drem_r[j][i][DRW-2:0], num_r[j][i][QB-1-j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      num_r[0][i]  <= num_nxt[i];
      drem_r[0][i] <= DRW'(num_nxt[i] >> QB);
      quo_r[0][i]  <= '0;
    end
    len_r[0]    <= res_r[ISQ][LW-1:0];
    neg_v_r[0]  <= neg_s_r[ISQ];
    zero_v_r[0] <= zero_s_r[ISQ];
    side_v_r[0] <= side_s_r[ISQ];
    for (int j = 0; j < QB; j++) begin
      for (int i = 0; i < 3; i++) begin
        if (dtry[j][i] >= DRW'(len_r[j])) begin
          drem_r[j+1][i] <= dtry[j][i] - DRW'(len_r[j]);
          quo_r[j+1][i]  <= {quo_r[j][i][QB-2:0], 1'b1};
        end else begin
          drem_r[j+1][i] <= dtry[j][i];
          quo_r[j+1][i]  <= {quo_r[j][i][QB-2:0], 1'b0};
        end
        num_r[j+1][i] <= num_r[j][i];
      end
      len_r[j+1]    <= len_r[j];
      neg_v_r[j+1]  <= neg_v_r[j];
      zero_v_r[j+1] <= zero_v_r[j];
      side_v_r[j+1] <= side_v_r[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (zero_v_r[QB]) begin
        out_vec_r[i] <= '0;
      end else if (neg_v_r[QB][i]) begin
        out_vec_r[i] <= -$signed({1'b0, quo_r[QB][i]});
      end else begin
        out_vec_r[i] <= $signed({1'b0, quo_r[QB][i]});
      end
    end
    side_o_r <= side_v_r[QB];
  end

  assign out_vld  = vld_r[LAT-1];
  assign out_vec  = out_vec_r;
  assign out_side = side_o_r;

endmodule

[hw/rtl/lav_cross.sv]
module lav_cross #(
  parameter int AW = 32,
  parameter int BW = 18,
  parameter int SW = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic signed [AW-1:0]   in_a [3],
  input  logic signed [BW-1:0]   in_b [3],
  input  logic [SW-1:0]          in_side,
  output logic                   out_vld,
  output logic signed [AW+BW:0]  out_vec [3],
  output logic [SW-1:0]          out_side
);

  localparam int PRW = AW + BW;
  localparam int OW  = PRW + 1;

  logic [1:0]            vld_r;
  logic signed [PRW-1:0] prod_r [6];
  logic [SW-1:0]         side_a_r;
  logic signed [OW-1:0]  vec_r [3];
  logic [SW-1:0]         side_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    prod_r[0] <= in_a[1] * in_b[2];
    prod_r[1] <= in_a[2] * in_b[1];
    prod_r[2] <= in_a[2] * in_b[0];
    prod_r[3] <= in_a[0] * in_b[2];
    prod_r[4] <= in_a[0] * in_b[1];
    prod_r[5] <= in_a[1] * in_b[0];
    side_a_r  <= in_side;
  end

  always_ff @(posedge clk) begin
    vec_r[0] <= OW'(prod_r[0]) - OW'(prod_r[1]);
    vec_r[1] <= OW'(prod_r[2]) - OW'(prod_r[3]);
    vec_r[2] <= OW'(prod_r[4]) - OW'(prod_r[5]);
    side_b_r <= side_a_r;
  end

  assign out_vld  = vld_r[1];
  assign out_vec  = vec_r;
  assign out_side = side_b_r;

endmodule

[hw/rtl/lav_shift.sv]
module lav_shift import lav_pkg::*; #(
  parameter int AW = 19
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [AW-1:0] in_axis [3],
  input  logic signed [QW-1:0] in_pos [3],
  output logic                 out_vld,
  output logic signed [AW-1:0] out_axis [3],
  output logic signed [QW-1:0] out_shift
);

  localparam int PRW = AW + QW;
  localparam int DW  = PRW + 2;

  logic [2:0]            vld_r;
  logic signed [PRW-1:0] prod_r [3];
  logic signed [AW-1:0]  axis_a_r [3];
  logic signed [DW-1:0]  sum_r;
  logic signed [AW-1:0]  axis_b_r [3];
  logic signed [63:0]    neg_w;
  logic signed [QW-1:0]  shift_r;
  logic signed [AW-1:0]  axis_c_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= in_axis[i] * in_pos[i];
    end
    axis_a_r <= in_axis;
  end

  always_ff @(posedge clk) begin
    sum_r    <= DW'(prod_r[0]) + DW'(prod_r[1]) + DW'(prod_r[2]);
    axis_b_r <= axis_a_r;
  end

  assign neg_w = -round16(64'(sum_r));

  always_ff @(posedge clk) begin
    if (neg_w > SAT_MAX) begin
      shift_r <= QW'(SAT_MAX);
    end else if (neg_w < SAT_MIN) begin
      shift_r <= QW'(SAT_MIN);
    end else begin
      shift_r <= QW'(neg_w);
    end
    axis_c_r <= axis_b_r;
  end

  assign out_vld   = vld_r[2];
  assign out_axis  = axis_c_r;
  assign out_shift = shift_r;

endmodule

[hw/rtl/look_at_view_matrix.sv]
// look_at_view_matrix: right-handed look-at view matrix, q16.16
// throughput: one item per cycle; busy stays low, the datapath is fully pipelined
// each normalizer holds a 31-stage square root and a 17-stage divider
// rst_n is synchronous, active low, and clears the valid bits only
// out_strobe is a one-cycle pulse; the receiver cannot stall
module look_at_view_matrix import lav_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  lav_in_t  in_item,
  output logic     out_strobe,
  output lav_out_t out_item
);

  localparam int DW  = QW + 2;
  localparam int CW1 = QW + AXW + 1;
  localparam int CW2 = 2 * AXW + 1;
  localparam int UW  = AXW + 1;
  localparam int S1W = 6 * QW;
  localparam int S2W = 3 * QW + 3 * AXW;
  localparam int S3W = 3 * QW + 6 * AXW;
  localparam int LAT = 119;

  logic                  v0_r;
  logic signed [QW-1:0]  p0_r [3];
  logic signed [QW-1:0]  up0_r [3];
  logic signed [DW-1:0]  d0_r [3];
  logic [S1W-1:0]        s1_in;

  logic                  v1;
  logic signed [AXW-1:0] b1 [3];
  logic [S1W-1:0]        s1_out;
  logic signed [QW-1:0]  p1 [3];
  logic signed [QW-1:0]  up1 [3];
  logic [S2W-1:0]        s2_in;

  logic                  v2;
  logic signed [CW1-1:0] c2 [3];
  logic [S2W-1:0]        s2_out;

  logic                  v3;
  logic signed [AXW-1:0] r3 [3];
  logic [S2W-1:0]        s3_out;
  logic signed [AXW-1:0] b3 [3];
  logic [S3W-1:0]        s3_in;

  logic                  v4;
  logic signed [CW2-1:0] w4 [3];
  logic [S3W-1:0]        s4_out;

  logic                  v5_r;
  logic signed [UW-1:0]  u5_r [3];
  logic signed [UW-1:0]  r5_r [3];
  logic signed [UW-1:0]  b5_r [3];
  logic signed [QW-1:0]  p5_r [3];

  logic [2:0]            sv_vld;
  logic signed [UW-1:0]  ra [3];
  logic signed [UW-1:0]  ua [3];
  logic signed [UW-1:0]  ba [3];
  logic signed [QW-1:0]  rs;
  logic signed [QW-1:0]  us;
  logic signed [QW-1:0]  bs;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    p0_r[0]  <= in_item.pos_x;
    p0_r[1]  <= in_item.pos_y;
    p0_r[2]  <= in_item.pos_z;
    up0_r[0] <= in_item.up_x;
    up0_r[1] <= in_item.up_y;
    up0_r[2] <= in_item.up_z;
    d0_r[0]  <= DW'(in_item.pos_x) - DW'(in_item.target_x);
    d0_r[1]  <= DW'(in_item.pos_y) - DW'(in_item.target_y);
    d0_r[2]  <= DW'(in_item.pos_z) - DW'(in_item.target_z);
  end

  assign s1_in = {p0_r[0], p0_r[1], p0_r[2], up0_r[0], up0_r[1], up0_r[2]};

  lav_unit #(.IW(DW), .SW(S1W)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v0_r),
    .in_vec   (d0_r),
    .in_side  (s1_in),
    .out_vld  (v1),
    .out_vec  (b1),
    .out_side (s1_out)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p1[i]  = s1_out[S1W-1-i*QW -: QW];
      up1[i] = s1_out[S1W-1-(3+i)*QW -: QW];
    end
  end

  assign s2_in = {p1[0], p1[1], p1[2], b1[0], b1[1], b1[2]};

  lav_cross #(.AW(QW), .BW(AXW), .SW(S2W)) u_side (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v1),
    .in_a     (up1),
    .in_b     (b1),
    .in_side  (s2_in),
    .out_vld  (v2),
    .out_vec  (c2),
    .out_side (s2_out)
  );

  lav_unit #(.IW(CW1), .SW(S2W)) u_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v2),
    .in_vec   (c2),
    .in_side  (s2_out),
    .out_vld  (v3),
    .out_vec  (r3),
    .out_side (s3_out)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b3[i] = s3_out[S2W-1-3*QW-i*AXW -: AXW];
    end
  end

  assign s3_in = {s3_out, r3[0], r3[1], r3[2]};

  lav_cross #(.AW(AXW), .BW(AXW), .SW(S3W)) u_upax (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v3),
    .in_a     (b3),
    .in_b     (r3),
    .in_side  (s3_in),
    .out_vld  (v4),
    .out_vec  (w4),
    .out_side (s4_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      u5_r[i] <= UW'(round16(64'(w4[i])));
      p5_r[i] <= s4_out[S3W-1-i*QW -: QW];
      b5_r[i] <= UW'($signed(s4_out[S3W-1-3*QW-i*AXW -: AXW]));
      r5_r[i] <= UW'($signed(s4_out[S3W-1-3*QW-(3+i)*AXW -: AXW]));
    end
  end

  lav_shift #(.AW(UW)) u_rrow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (v5_r),
    .in_axis   (r5_r),
    .in_pos    (p5_r),
    .out_vld   (sv_vld[0]),
    .out_axis  (ra),
    .out_shift (rs)
  );

  lav_shift #(.AW(UW)) u_urow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (v5_r),
    .in_axis   (u5_r),
    .in_pos    (p5_r),
    .out_vld   (sv_vld[1]),
    .out_axis  (ua),
    .out_shift (us)
  );

  lav_shift #(.AW(UW)) u_brow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (v5_r),
    .in_axis   (b5_r),
    .in_pos    (p5_r),
    .out_vld   (sv_vld[2]),
    .out_axis  (ba),
    .out_shift (bs)
  );

  assign out_strobe = &sv_vld;

  always_comb begin
    out_item.right_axis_x = QW'(ra[0]);
    out_item.right_axis_y = QW'(ra[1]);
    out_item.right_axis_z = QW'(ra[2]);
    out_item.right_shift  = rs;
    out_item.true_up_x    = QW'(ua[0]);
    out_item.true_up_y    = QW'(ua[1]);
    out_item.true_up_z    = QW'(ua[2]);
    out_item.up_shift     = us;
    out_item.back_axis_x  = QW'(ba[0]);
    out_item.back_axis_y  = QW'(ba[1]);
    out_item.back_axis_z  = QW'(ba[2]);
    out_item.back_shift   = bs;
  end

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_strobe)
    else $error("item lost in the pipeline");

  a_rows_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (sv_vld[0] == sv_vld[1]) && (sv_vld[1] == sv_vld[2]))
    else $error("row pipelines out of step");

  a_zero_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.back_axis_x == '0 && out_item.back_axis_y == '0 &&
    out_item.back_axis_z == '0 |->
    out_item.right_axis_x == '0 && out_item.right_axis_y == '0 &&
    out_item.right_axis_z == '0 && out_item.true_up_x == '0 &&
    out_item.true_up_y == '0 && out_item.true_up_z == '0)
    else $error("zero back axis with nonzero right or up axis");

  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |->
    out_item.right_axis_x <= 32'sd65536 && out_item.right_axis_x >= -32'sd65536 &&
    out_item.back_axis_x <= 32'sd65536 && out_item.back_axis_x >= -32'sd65536)
    else $error("unit axis component out of range");

endmodule
